### rtl/core/gsep_pkg.sv
// Shared constants for the grid exit-path solver.
`default_nettype none
package gsep_pkg;
  localparam int GridSide  = 64;
  localparam int SideW     = $clog2(GridSide);
  localparam int CellCount = GridSide * GridSide;
  localparam int CellW     = 2 * SideW;
  localparam int ExtW      = SideW + 1;
  localparam int StepsW    = 13;
  localparam int DistW     = CellW + 1;
  localparam int QPtrW     = CellW + 1;
  localparam logic [StepsW-1:0] StepsMax = '1;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] CELL_OPEN = 2'd0;
  localparam logic [1:0] CELL_WALL = 2'd1;
  localparam logic [1:0] CELL_START = 2'd2;
  localparam logic [1:0] MARK_PATH = 2'd3;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_UP = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;
endpackage
`default_nettype wire

### rtl/core/gsep_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module gsep_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/grid_shortest_exit_path.sv
// Top level of the grid exit-path solver: sequencer around cell, tag and queue RAMs.
// Results: a write is answered from its accept, a read via the S_RD state; result held in an output register.
// Search: clear pass over all tag entries, seed scan for the first start cell of each used
//   row, then per dequeued non-border cell a check of each neighbor, then a path trace.
// Sequential: one request at a time; a search holds the block until done.
// Reset: control state cleared; grid RAM undefined until written; path and
//   visited tags valid after the first search's clear pass (pathclr_q set by it).
`default_nettype none
module grid_shortest_exit_path
  import gsep_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [SideW-1:0]  row_i,
  input  wire logic [SideW-1:0]  col_i,
  input  wire logic [1:0]        cell_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   found_o,
  output logic [StepsW-1:0]      steps_o,
  output logic [1:0]             mark_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [ExtW-1:0]   cfg_data_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CLR, S_SCAN, S_SCANW, S_DEQ, S_DEQW,
    S_NB, S_NBW, S_TR, S_TRW, S_DONE
  } state_e;

  state_e state_q;
  logic [ExtW-1:0] rows_q, cols_q, nr, nc;
  logic [CellW-1:0] cnt_q, cur_q;
  logic [DistW-1:0] dist_q;
  logic [QPtrW-1:0] head_q, tail_q;
  logic [1:0] dir_q;
  logic pathclr_q;

  // saturate extents to 1..GridSide
  always_comb begin
    nr = (rows_q == '0) ? ExtW'(1) : (rows_q > ExtW'(GridSide) ? ExtW'(GridSide) : rows_q);
    nc = (cols_q == '0) ? ExtW'(1) : (cols_q > ExtW'(GridSide) ? ExtW'(GridSide) : cols_q);
  end

  // grid RAM
  logic g_we; logic [CellW-1:0] g_wa, g_ra; logic [1:0] g_wd, g_rd;
  gsep_ram #(.Width(2), .Depth(CellCount)) u_grid (.clk_i, .we_i(g_we), .waddr_i(g_wa),
    .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd));
  // tag RAM: {path, visited, parent dir}
  logic t_we; logic [CellW-1:0] t_wa, t_ra; logic [3:0] t_wd, t_rd;
  gsep_ram #(.Width(4), .Depth(CellCount)) u_tag (.clk_i, .we_i(t_we), .waddr_i(t_wa),
    .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));
  // queue RAM: {cell, dist}
  logic q_we; logic [CellW-1:0] q_wa, q_ra; logic [CellW+DistW-1:0] q_wd, q_rd;
  gsep_ram #(.Width(CellW+DistW), .Depth(CellCount)) u_queue (.clk_i, .we_i(q_we),
    .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd));

  logic [SideW-1:0] cr, cc, nbr, nbc;
  logic nb_ok;
  assign cr = cur_q[CellW-1:SideW];
  assign cc = cur_q[SideW-1:0];
  // neighbor of current cell in direction dir_q, with bound check
  always_comb begin
    nbr = cr; nbc = cc; nb_ok = 1'b0;
    unique case (dir_q)
      DIR_RIGHT: begin nbc = cc + 1'b1; nb_ok = ExtW'(cc) + 1'b1 < nc; end
      DIR_DOWN:  begin nbr = cr + 1'b1; nb_ok = ExtW'(cr) + 1'b1 < nr; end
      DIR_LEFT:  begin nbc = cc - 1'b1; nb_ok = cc != '0; end
      default:   begin nbr = cr - 1'b1; nb_ok = cr != '0; end
    endcase
  end
  logic [SideW-1:0] qr, qc;
  logic border;
  assign qr = q_rd[CellW+DistW-1:DistW+SideW];
  assign qc = q_rd[DistW+SideW-1:DistW];
  assign border = qr == '0 || ExtW'(qr) == nr - 1'b1 || qc == '0 || ExtW'(qc) == nc - 1'b1;
  logic [SideW-1:0] sr, sc;
  assign sr = cnt_q[CellW-1:SideW];
  assign sc = cnt_q[SideW-1:0];

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_o && out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;

  // a result is loaded this cycle; takes priority over the output drain
  logic out_set;
  assign out_set = (state_q == S_IDLE && in_acc && kind_i != KIND_SEARCH &&
                    kind_i != KIND_READ) || state_q == S_RD || state_q == S_DONE;

  logic [CellW-1:0] pcell;
  always_comb begin
    unique case (t_rd[1:0])
      DIR_RIGHT: pcell = cur_q - 1'b1;
      DIR_DOWN:  pcell = cur_q - CellW'(GridSide);
      DIR_LEFT:  pcell = cur_q + 1'b1;
      default:   pcell = cur_q + CellW'(GridSide);
    endcase
  end

  // RAM port control
  always_comb begin
    g_we = in_acc && kind_i == KIND_WRITE;
    g_wa = {row_i, col_i};
    g_wd = (cell_req_i == MARK_PATH) ? CELL_WALL : cell_req_i;
    g_ra = {row_i, col_i};
    t_ra = {row_i, col_i};
    t_we = 1'b0; t_wa = cur_q; t_wd = '0;
    q_we = 1'b0; q_wa = tail_q[CellW-1:0]; q_wd = '0;
    q_ra = head_q[CellW-1:0];
    unique case (state_q)
      S_CLR: begin t_we = 1'b1; t_wa = cnt_q; t_wd = '0; end
      S_SCAN: g_ra = cnt_q;
      S_NB: begin g_ra = {nbr, nbc}; t_ra = {nbr, nbc}; end
      S_NBW: begin
        t_wa = {nbr, nbc}; t_wd = {1'b0, 1'b1, dir_q};
        t_we = nb_ok && g_rd == CELL_OPEN && !t_rd[2];
        q_we = t_we; q_wd = {nbr, nbc, dist_q + 1'b1};
      end
      S_SCANW: begin
        q_we = g_rd == CELL_START; q_wd = {cnt_q, DistW'(0)};
        t_we = q_we; t_wa = cnt_q; t_wd = 4'b0100;
      end
      S_TR: t_ra = cur_q;
      S_TRW: begin t_we = 1'b1; t_wa = cur_q; t_wd = {1'b1, t_rd[2:0]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rows_q <= ExtW'(GridSide); cols_q <= ExtW'(GridSide);
      out_valid_o <= 1'b0; found_o <= 1'b0; steps_o <= '0; mark_o <= '0;
      cnt_q <= '0; cur_q <= '0; dist_q <= '0; head_q <= '0; tail_q <= '0;
      dir_q <= '0; pathclr_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ROWS) rows_q <= cfg_data_i;
        else cols_q <= cfg_data_i;
      end
      if (out_valid_o && !out_stall_i && !out_set) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          found_o <= 1'b0; steps_o <= '0; mark_o <= '0;
          if (kind_i == KIND_SEARCH) begin
            state_q <= S_CLR; cnt_q <= '0;
          end else if (kind_i == KIND_READ) state_q <= S_RD;
          else out_valid_o <= 1'b1;
        end
        S_RD: begin
          // tag RAM garbage before first search: path bits read as 0
          mark_o <= (g_rd == CELL_OPEN && pathclr_q && t_rd[3]) ? MARK_PATH : g_rd;
          out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
        S_CLR: begin
          // counter wraps to zero on the last entry
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) begin
            state_q <= S_SCAN; head_q <= '0; tail_q <= '0; pathclr_q <= 1'b1;
          end
        end
        S_SCAN: state_q <= S_SCANW;
        S_SCANW: begin
          if (g_rd == CELL_START || ExtW'(sc) + 1'b1 >= nc) begin
            if (g_rd == CELL_START) tail_q <= tail_q + 1'b1;
            if (ExtW'(sr) + 1'b1 >= nr) state_q <= S_DEQ;
            else begin cnt_q <= {sr + 1'b1, SideW'(0)}; state_q <= S_SCAN; end
          end else begin
            cnt_q <= cnt_q + 1'b1; state_q <= S_SCAN;
          end
        end
        S_DEQ: begin
          if (head_q == tail_q) begin
            found_o <= 1'b0; steps_o <= '0; state_q <= S_DONE;
          end else state_q <= S_DEQW;
        end
        S_DEQW: begin
          head_q <= head_q + 1'b1;
          cur_q <= q_rd[CellW+DistW-1:DistW]; dist_q <= q_rd[DistW-1:0];
          if (border) begin
            found_o <= 1'b1;
            steps_o <= (q_rd[DistW-1:0] + 1'b1 > DistW'(StepsMax)) ? StepsMax
                       : StepsW'(q_rd[DistW-1:0] + 1'b1);
            state_q <= S_TR;
          end else begin
            dir_q <= DIR_RIGHT; state_q <= S_NB;
          end
        end
        S_NB: state_q <= S_NBW;
        S_NBW: begin
          if (q_we) tail_q <= tail_q + 1'b1;
          dir_q <= dir_q + 1'b1;
          state_q <= (dir_q == DIR_UP) ? S_DEQ : S_NB;
        end
        S_TR: state_q <= S_TRW;
        S_TRW: begin
          if (dist_q == '0) state_q <= S_DONE;
          else begin cur_q <= pcell; dist_q <= dist_q - 1'b1; state_q <= S_TR; end
        end
        S_DONE: begin out_valid_o <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("queue head passed tail");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_o) else $error("search result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_o || steps_o != '0 || !out_valid_o) else $error("found with zero steps");
endmodule
`default_nettype wire

### bench/tb_grid_shortest_exit_path.sv
// Self-checking testbench for the grid exit-path solver.
`timescale 1ns / 100ps
module tb_grid_shortest_exit_path;
  import gsep_pkg::*;

  typedef struct {
    logic              found;
    logic [StepsW-1:0] steps;
    logic [1:0]        mark;
  } answer_t;

  // one directed request; "typed" rows carry the answer written out by hand
  typedef struct {
    logic [1:0] kind;
    int         r;
    int         c;
    logic [1:0] req;
    bit         typed;
    answer_t    ans;
  } directed_t;

  localparam int NumDirected = 21;
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 25;
  // written area: top-left core plus the whole first row and first column
  localparam int FillCore    = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i = KIND_WRITE;
  logic [SideW-1:0]  row_i = '0;
  logic [SideW-1:0]  col_i = '0;
  logic [1:0]        cell_req_i = CELL_OPEN;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              found_o;
  logic [StepsW-1:0] steps_o;
  logic [1:0]        mark_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = REG_ROWS;
  logic [ExtW-1:0]   cfg_data_i = '0;

  grid_shortest_exit_path dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Maze model: grid contents, search tags and the pending answers
  // ---------------------------------------------------------------------------
  logic [1:0] maze [CellCount];
  bit         seen [CellCount];
  logic [1:0] came_from [CellCount];
  bit         on_path [CellCount];
  int         frontier_cell [CellCount];
  int         frontier_dist [CellCount];
  int         used_rows = GridSide;
  int         used_cols = GridSide;
  answer_t    pending_answers [$];
  int         errors = 0;

  function automatic int clamp_extent(int v);
    if (v < 1) return 1;
    if (v > GridSide) return GridSide;
    return v;
  endfunction

  // Breadth-first walk from the row seeds; returns steps (0 when no exit).
  function automatic int walk_to_exit(output logic hit);
    int head, tail, r, c, tr, tc, pos, t, d, k;
    int dr[4] = '{0, 1, 0, -1};
    int dc[4] = '{1, 0, -1, 0};
    head = 0;
    tail = 0;
    hit = 1'b0;
    for (int i = 0; i < CellCount; i++) begin
      seen[i] = 0;
      on_path[i] = 0;
    end
    // first start cell of each used row, in row order
    for (r = 0; r < used_rows; r++) begin
      for (c = 0; c < used_cols; c++) begin
        if (maze[r*GridSide+c] == CELL_START) begin
          seen[r*GridSide+c] = 1;
          frontier_cell[tail] = r*GridSide+c;
          frontier_dist[tail] = 0;
          tail++;
          break;
        end
      end
    end
    while (head < tail) begin
      pos = frontier_cell[head];
      d = frontier_dist[head];
      head++;
      r = pos / GridSide;
      c = pos % GridSide;
      if (r == 0 || r == used_rows-1 || c == 0 || c == used_cols-1) begin
        hit = 1'b1;
        for (k = 0; k < d; k++) begin
          on_path[pos] = 1;
          case (came_from[pos])
            DIR_RIGHT: pos -= 1;
            DIR_DOWN:  pos -= GridSide;
            DIR_LEFT:  pos += 1;
            default:   pos += GridSide;
          endcase
        end
        on_path[pos] = 1;
        return (d + 1 > int'(StepsMax)) ? int'(StepsMax) : d + 1;
      end
      for (k = 0; k < 4; k++) begin
        tr = r + dr[k];
        tc = c + dc[k];
        if (tr < 0 || tc < 0 || tr >= used_rows || tc >= used_cols) continue;
        t = tr*GridSide + tc;
        if (maze[t] != CELL_OPEN || seen[t]) continue;
        came_from[t] = k[1:0];
        seen[t] = 1;
        frontier_cell[tail] = t;
        frontier_dist[tail] = d + 1;
        tail++;
      end
    end
    return 0;
  endfunction

  // Applies one accepted request to the model and returns its answer.
  function automatic answer_t apply_request(logic [1:0] kind, int r, int c, logic [1:0] req);
    answer_t a;
    logic hit;
    int n;
    int addr;
    a = '{1'b0, '0, 2'd0};
    addr = r*GridSide + c;
    case (kind)
      KIND_WRITE: maze[addr] = (req == MARK_PATH) ? CELL_WALL : req;
      KIND_SEARCH: begin
        n = walk_to_exit(hit);
        a.found = hit;
        a.steps = n[StepsW-1:0];
      end
      KIND_READ: a.mark = (maze[addr] == CELL_OPEN && on_path[addr]) ? MARK_PATH : maze[addr];
      default: ;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one request and returns at the edge that takes it. valid stays
  // high across back-to-back requests so it is never dropped and raised in
  // the same step.
  task automatic send_request(logic [1:0] kind, int r, int c, logic [1:0] req, int gap,
                              bit typed, answer_t typed_ans);
    answer_t a;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    row_i      <= r[SideW-1:0];
    col_i      <= c[SideW-1:0];
    cell_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    a = apply_request(kind, r, c, req);
    pending_answers.push_back(typed ? typed_ans : a);
  endtask

  // Register writes only with nothing in flight.
  task automatic write_extent(logic idx, int value);
    in_valid_i <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[ExtW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROWS) used_rows = clamp_extent(value);
    else used_cols = clamp_extent(value);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare at the accepting edge
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0:       begin out_stall_i <= 1'b1; stall_left <= $urandom_range(10, 40); end
        1:       begin out_stall_i <= 1'b0; stall_left <= $urandom_range(20, 80); end
        2, 3, 4: begin out_stall_i <= 1'b1; stall_left <= $urandom_range(0, 3); end
        default: begin out_stall_i <= 1'b0; stall_left <= $urandom_range(0, 3); end
      endcase
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result found=%0d steps=%0d mark=%0d", $time,
                 found_o, steps_o, mark_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, found_o);
          errors++;
        end
        if (steps_o !== want.steps) begin
          $display("%0t: steps expected %0d actual %0d", $time, want.steps, steps_o);
          errors++;
        end
        if (mark_o !== want.mark) begin
          $display("%0t: mark expected %0d actual %0d", $time, want.mark, mark_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  directed_t directed [NumDirected];
  // every used area stays inside the written area
  int phase_rows [NumPhases] = '{8, 1, 127, 0, 64, 1, 7, 4, 6, 3};
  int phase_cols [NumPhases] = '{8, 64, 1, 6, 1, 127, 5, 4, 0, 8};
  answer_t zero_ans = '{1'b0, '0, 2'd0};

  initial begin
    int p, r, c;
    logic [1:0] k, req;
    // all open, no start yet: search finds nothing
    directed[0]  = '{KIND_SEARCH, 0, 0, CELL_OPEN, 1, '{1'b0, 13'd0, 2'd0}};
    directed[1]  = '{KIND_WRITE, 0, 5, CELL_START, 1, '{1'b0, 13'd0, 2'd0}};
    // seed on the border
    directed[2]  = '{KIND_SEARCH, 0, 0, CELL_OPEN, 1, '{1'b1, 13'd1, 2'd0}};
    directed[3]  = '{KIND_READ, 0, 5, CELL_OPEN, 1, '{1'b0, 13'd0, CELL_START}};
    // path bit survives a later write
    directed[4]  = '{KIND_WRITE, 0, 5, CELL_OPEN, 1, '{1'b0, 13'd0, 2'd0}};
    directed[5]  = '{KIND_READ, 0, 5, CELL_OPEN, 1, '{1'b0, 13'd0, MARK_PATH}};
    // cell type three stores a wall
    directed[6]  = '{KIND_WRITE, 1, 1, MARK_PATH, 1, '{1'b0, 13'd0, 2'd0}};
    directed[7]  = '{KIND_READ, 1, 1, CELL_OPEN, 1, '{1'b0, 13'd0, CELL_WALL}};
    // unused kind
    directed[8]  = '{2'd3, 63, 63, MARK_PATH, 1, '{1'b0, 13'd0, 2'd0}};
    directed[9]  = '{KIND_WRITE, 0, 5, CELL_WALL, 1, '{1'b0, 13'd0, 2'd0}};
    // seed in the middle of the open 8x8 area
    directed[10] = '{KIND_WRITE, 4, 4, CELL_START, 1, '{1'b0, 13'd0, 2'd0}};
    directed[11] = '{KIND_SEARCH, 0, 0, CELL_OPEN, 0, zero_ans};
    directed[12] = '{KIND_READ, 4, 5, CELL_OPEN, 0, zero_ans};
    directed[13] = '{KIND_READ, 4, 7, CELL_OPEN, 0, zero_ans};
    directed[14] = '{KIND_READ, 7, 4, CELL_OPEN, 0, zero_ans};
    directed[15] = '{KIND_WRITE, 7, 7, CELL_WALL, 1, '{1'b0, 13'd0, 2'd0}};
    directed[16] = '{KIND_READ, 7, 7, CELL_OPEN, 1, '{1'b0, 13'd0, CELL_WALL}};
    // middle seed walled off; a corner seed on the last row exits at once
    directed[17] = '{KIND_WRITE, 4, 4, CELL_WALL, 1, '{1'b0, 13'd0, 2'd0}};
    directed[18] = '{KIND_WRITE, 7, 0, CELL_START, 1, '{1'b0, 13'd0, 2'd0}};
    directed[19] = '{KIND_SEARCH, 0, 0, CELL_OPEN, 1, '{1'b1, 13'd1, 2'd0}};
    directed[20] = '{KIND_WRITE, 7, 0, CELL_WALL, 1, '{1'b0, 13'd0, 2'd0}};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // open the written area so nothing unwritten is ever read or searched
    for (int i = 0; i < CellCount; i++)
      if ((i / GridSide < FillCore && i % GridSide < FillCore) ||
          i / GridSide == 0 || i % GridSide == 0)
        send_request(KIND_WRITE, i / GridSide, i % GridSide, CELL_OPEN,
                     ($urandom_range(0, 63) == 0) ? pick_gap() : 0, 0, zero_ans);

    write_extent(REG_ROWS, FillCore);
    write_extent(REG_COLS, FillCore);
    foreach (directed[i])
      send_request(directed[i].kind, directed[i].r, directed[i].c, directed[i].req,
                   pick_gap(), directed[i].typed, directed[i].ans);

    for (p = 0; p < NumPhases; p++) begin
      // the write task drains first, so the sender waits out every answer here
      write_extent(REG_ROWS, phase_rows[p]);
      write_extent(REG_COLS, phase_cols[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        // mostly maze building inside the used area, reads and a few searches
        case ($urandom_range(0, 99)) inside
          [0:54]: begin
            k = KIND_WRITE;
            r = $urandom_range(0, used_rows - 1);
            c = $urandom_range(0, used_cols - 1);
            case ($urandom_range(0, 19)) inside
              [0:10]:  req = CELL_OPEN;
              [11:16]: req = CELL_WALL;
              [17:18]: req = CELL_START;
              default: req = MARK_PATH;
            endcase
          end
          [55:62]: begin
            k = KIND_WRITE;
            r = $urandom_range(0, GridSide - 1);
            c = $urandom_range(0, GridSide - 1);
            req = 2'($urandom_range(0, 3));
          end
          [63:86]: begin
            k = KIND_READ;
            // now and then a read of the core area outside the used one
            if ($urandom_range(0, 3) == 0) begin
              r = $urandom_range(0, FillCore - 1);
              c = $urandom_range(0, FillCore - 1);
            end else begin
              r = $urandom_range(0, used_rows - 1);
              c = $urandom_range(0, used_cols - 1);
            end
            req = 2'($urandom_range(0, 3));
          end
          [87:98]: begin
            k = KIND_SEARCH;
            r = $urandom_range(0, GridSide - 1);
            c = $urandom_range(0, GridSide - 1);
            req = 2'($urandom_range(0, 3));
          end
          default: begin
            k = 2'd3;
            r = $urandom_range(0, GridSide - 1);
            c = $urandom_range(0, GridSide - 1);
            req = 2'($urandom_range(0, 3));
          end
        endcase
        send_request(k, r, c, req, pick_gap(), 0, zero_ans);
      end
    end

    in_valid_i <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_grid_shortest_exit_path: clean");
    end else begin
      $display("tb_grid_shortest_exit_path: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(80_000_000);
    $display("tb_grid_shortest_exit_path: errors");
    $finish;
  end

endmodule
